FILE: hdl/itrd_pkg.sv
// Shared types, constants and helpers of the integer-to-radix-digits block.
// Used by itrd_ctrl, itrd_dp and integer_to_radix_digits; depends on nothing.
package itrd_pkg;

    // Widths fixed by the beat formats.
    localparam int DATA_W        = 32;
    localparam int CHAR_W        = 8;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int RADIX_W       = 5;
    localparam int ALPHA_CHARS   = 16;
    localparam int ALPHA_W       = ALPHA_CHARS * CHAR_W;
    localparam int NDIG_MAX      = 32;
    localparam int NDIG_W        = $clog2(NDIG_MAX + 1);
    localparam int STACK_IDX_W   = $clog2(NDIG_MAX);

    // Divider: four quotient bits per cycle.
    localparam int BITS_PER_STEP = 4;
    localparam int DIV_STEPS     = DATA_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(DIV_STEPS);

    // Default for the largest supported radix.
    localparam int MAX_RADIX_DEF = 16;

    // Special characters.
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX_LEN   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // take a new input beat
        logic div_step;    // run one divider step
        logic emit_sign;   // load '-' into the output register
        logic emit_digit;  // pop one digit into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic alpha_ok;    // alphabet and radix are usable
        logic negative;    // current value is negative
        logic div_last;    // this divider cycle finishes a digit
        logic mag_zero;    // remaining quotient is zero
        logic stack_full;  // the digit stack holds the maximum count
        logic out_free;    // the output register can take a beat
        logic last_digit;  // one digit left on the stack
    } t_dp_stat;

    // Alphabet character k out of the packed 16-character alphabet.
    function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] alpha,
                                                     input logic [3:0] k);
        return alpha[{k, 3'b000} +: CHAR_W];
    endfunction

endpackage

FILE: hdl/itrd_ctrl.sv
// Controller state machine of the integer-to-radix-digits block.
// Depends on itrd_pkg; drives the datapath itrd_dp through command and status structs.
module itrd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  itrd_pkg::t_dp_stat  i_stat,
    output itrd_pkg::t_dp_cmd   o_cmd
);
    import itrd_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DIV   = 6'b000100,
        S_NEXT  = 6'b001000,
        S_SIGN  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Input is taken only between conversions.
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                // A bad alphabet drops the beat without output.
                n_state = i_stat.alpha_ok ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_stat.mag_zero || i_stat.stack_full) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_SIGN: begin
                if (!i_stat.negative) begin
                    n_state = S_EMIT;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_stat.last_digit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/itrd_dp.sv
// Datapath of the integer-to-radix-digits block: configuration registers, alphabet
// check, iterative divider, digit stack and output register. Depends on itrd_pkg.
module itrd_dp #(
    parameter int MAX_RADIX = itrd_pkg::MAX_RADIX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [itrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [itrd_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [itrd_pkg::DATA_W-1:0]         i_in_data,
    input  itrd_pkg::t_dp_cmd                   i_cmd,
    output itrd_pkg::t_dp_stat                  o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [itrd_pkg::CHAR_W-1:0]         o_out_char,
    output logic                                o_out_last
);
    import itrd_pkg::*;

    localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;

    // Configuration registers.
    logic [CFG_W-1:0]   r_alpha_lower;
    logic [CFG_W-1:0]   r_alpha_upper;
    logic [RADIX_W-1:0] r_radix_len;
    logic               r_alpha_ok;
    logic               n_alpha_ok;
    logic [ALPHA_W-1:0] alpha;

    assign alpha = {r_alpha_upper, r_alpha_lower};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_lower <= '0;
            r_alpha_upper <= '0;
            r_radix_len   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ALPHA_LOWER) begin
                r_alpha_lower <= i_cfg_data;
            end
            if (i_cfg_index == CFG_ALPHA_UPPER) begin
                r_alpha_upper <= i_cfg_data;
            end
            if (i_cfg_index == CFG_RADIX_LEN) begin
                r_radix_len <= i_cfg_data[RADIX_W-1:0];
            end
        end
    end

    // Alphabet check: the length is 2 to MAX_RADIX and every character in use is nonzero,
    // not a sign or space, and unique among those in use; registered to settle before use.
    always_comb begin
        logic [CHAR_W-1:0] cp;
        n_alpha_ok = (r_radix_len >= RADIX_W'(2)) && (r_radix_len <= RADIX_W'(MAX_RADIX));
        for (int p = 0; p < ALPHA_CHARS; p++) begin
            cp = alpha_char(alpha, 4'(p));
            if (RADIX_W'(p) < r_radix_len) begin
                if (cp == '0 || cp == CHAR_PLUS || cp == CHAR_MINUS || cp == CHAR_SPACE) begin
                    n_alpha_ok = 1'b0;
                end
                for (int q = p + 1; q < ALPHA_CHARS; q++) begin
                    if (RADIX_W'(q) < r_radix_len && alpha_char(alpha, 4'(q)) == cp) begin
                        n_alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_ok <= 1'b0;
        end else begin
            r_alpha_ok <= n_alpha_ok;
        end
    end

    // Divider state. The dividend shifts out of r_mag at the top while the
    // quotient bits shift in at the bottom.
    logic [DATA_W-1:0]     r_mag;
    logic [DATA_W-1:0]     n_mag;
    logic                  r_neg;
    logic [DIGIT_W-1:0]    r_rem;
    logic [DIGIT_W-1:0]    n_rem;
    logic [STEP_CNT_W-1:0] r_step_cnt;
    logic [DIGIT_W:0]      radix_t;
    logic                  div_last;

    assign radix_t  = r_radix_len[DIGIT_W:0];
    assign div_last = (r_step_cnt == STEP_CNT_W'(DIV_STEPS - 1));

    // Four restoring division steps on a narrow remainder.
    always_comb begin
        logic [DIGIT_W:0] trial;
        n_rem = (r_step_cnt == '0) ? '0 : r_rem;
        n_mag = r_mag;
        for (int i = 0; i < BITS_PER_STEP; i++) begin
            trial = {n_rem, n_mag[DATA_W-1]};
            n_mag = {n_mag[DATA_W-2:0], 1'b0};
            if (trial >= radix_t) begin
                trial    = trial - radix_t;
                n_mag[0] = 1'b1;
            end
            n_rem = trial[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_cnt <= '0;
        end else if (i_cmd.load) begin
            r_step_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_step_cnt <= r_step_cnt + STEP_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_in_data[DATA_W-1];
            r_mag <= i_in_data[DATA_W-1] ? (DATA_W'(0) - i_in_data) : i_in_data;
        end else if (i_cmd.div_step) begin
            r_mag <= n_mag;
            r_rem <= n_rem;
        end
    end

    // Digit stack: remainders come least significant first, leave most significant first.
    logic [DIGIT_W-1:0]     r_digits [NDIG_MAX];
    logic [NDIG_W-1:0]      r_ndig;
    logic [STACK_IDX_W-1:0] top_idx;

    assign top_idx = r_ndig[STACK_IDX_W-1:0] - STACK_IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ndig <= '0;
        end else if (i_cmd.load) begin
            r_ndig <= '0;
        end else if (i_cmd.div_step && div_last) begin
            r_ndig <= r_ndig + NDIG_W'(1);
        end else if (i_cmd.emit_digit) begin
            r_ndig <= r_ndig - NDIG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && div_last) begin
            r_digits[r_ndig[STACK_IDX_W-1:0]] <= n_rem;
        end
    end

    // Output register: one beat waits here while the next one is prepared.
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;
    logic              out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= alpha_char(alpha, 4'(r_digits[top_idx]));
            r_out_last <= (r_ndig == NDIG_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

    // Status toward the controller.
    always_comb begin
        o_stat            = '0;
        o_stat.alpha_ok   = r_alpha_ok;
        o_stat.negative   = r_neg;
        o_stat.div_last   = div_last;
        o_stat.mag_zero   = (r_mag == '0);
        o_stat.stack_full = (r_ndig == NDIG_W'(NDIG_MAX));
        o_stat.out_free   = out_free;
        o_stat.last_digit = (r_ndig == NDIG_W'(1));
    end

    // A beat is never loaded over one that is still waiting.
    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_sign || i_cmd.emit_digit) |-> out_free)
        else $error("output register overwritten while stalled");

    // Pops happen only with digits on the stack.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_digit |-> (r_ndig != '0))
        else $error("digit popped from an empty stack");

    // The divider never runs once the stack holds the maximum digit count.
    a_div_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_ndig != NDIG_W'(NDIG_MAX)))
        else $error("divider running with a full digit stack");

    // A last beat is loaded only when the stack is then empty.
    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_digit && r_ndig == NDIG_W'(1)) |=> (r_ndig == '0 && r_out_last))
        else $error("final character does not empty the stack");

endmodule

FILE: hdl/integer_to_radix_digits.sv
// Integer-to-radix-digits converter: a 32-bit signed beat in, one character beat out
// per digit, most significant first, with a leading '-' for negative values. The radix
// is the configured alphabet length (2 up to MAX_RADIX); an alphabet that is too short
// or too long, or holds a zero, '+', '-', space or a repeated character drops the beat
// with no output. For each digit the shared remainder divider, which retires four
// quotient bits per cycle, runs in S_DIV and S_NEXT then tests the quotient; after the
// sign, the characters leave through the output register as the receiver takes them.
// A new input beat is taken once the previous value's last character sits in the
// output register. Configuration writes are registered, and the alphabet check on
// them is registered once more. Depends on itrd_pkg, itrd_ctrl, itrd_dp.
module integer_to_radix_digits #(
    parameter int MAX_RADIX = itrd_pkg::MAX_RADIX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream; tdata: number_value [31:0].
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [itrd_pkg::DATA_W-1:0]     i_s_axis_tdata,
    // Output stream; tdata: out_char [7:0]; tlast: last_flag.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [itrd_pkg::CHAR_W-1:0]     o_m_axis_tdata,
    output logic                            o_m_axis_tlast,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [itrd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [itrd_pkg::CFG_W-1:0]      i_cfg_data
);
    import itrd_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    itrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    itrd_dp #(
        .MAX_RADIX (MAX_RADIX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_char  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule
